// ----- sv/cabp_pkg.sv -----
// ----------------------------------------------------------------------------
// Conflict-aware bin packer package
// Shared sizes, register indexes, policy and action codes and the bin store entry type.
// ----------------------------------------------------------------------------
package cabp_pkg;

    // Sizing of the bin store and the item identifier space.
    localparam int MAX_BINS  = 64;
    localparam int MAX_ITEMS = 64;
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int COUNT_W   = $clog2(MAX_BINS + 1);

    // Field widths of the items on the channels.
    localparam int ID_W      = 6;
    localparam int WEIGHT_W  = 16;
    localparam int MASK_W    = 64;
    localparam int ROOM_W    = 17;
    localparam int IDX_OUT_W = 6;
    localparam int USED_W    = 7;
    localparam int CAP_W     = 16;
    localparam int POL_W     = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 2'd1;

    // Placement policies; the unused code behaves as first fit.
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    // Input actions.
    localparam logic ACT_PLACE = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // Reset value of the capacity register.
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'hFFFF;

    // Bits of a conflict mask that name real items.
    localparam logic [MASK_W-1:0] ITEM_MASK =
        (MAX_ITEMS >= MASK_W) ? {MASK_W{1'b1}} :
        ((MASK_W'(1) << MAX_ITEMS) - MASK_W'(1));

    // One entry of the bin store: member mask and signed remaining room.
    typedef struct packed {
        logic [MASK_W-1:0]        members;
        logic signed [ROOM_W-1:0] room;
    } t_bin_entry;

endpackage

// ----- sv/cabp_ifs.sv -----
// ----------------------------------------------------------------------------
// Conflict-aware bin packer channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface cabp_in_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic [cabp_pkg::ID_W-1:0]        item_id;
    logic [cabp_pkg::WEIGHT_W-1:0]    weight;
    logic [cabp_pkg::MASK_W-1:0]      conflict_mask;

    modport source (output valid, action, item_id, weight, conflict_mask, input ready);
    modport sink   (input valid, action, item_id, weight, conflict_mask, output ready);
endinterface

interface cabp_out_if;
    logic                                valid;
    logic                                ready;
    logic [cabp_pkg::IDX_OUT_W-1:0]      bin_index;
    logic                                new_bin;
    logic signed [cabp_pkg::ROOM_W-1:0]  bin_remaining;
    logic [cabp_pkg::USED_W-1:0]         bins_used;
    logic                                overflow;

    modport source (output valid, bin_index, new_bin, bin_remaining, bins_used, overflow,
                    input ready);
    modport sink   (input valid, bin_index, new_bin, bin_remaining, bins_used, overflow,
                    output ready);
endinterface

interface cabp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cabp_pkg::CFG_IDX_W-1:0]    index;
    logic [cabp_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/conflict_aware_bin_packer.sv -----
// ----------------------------------------------------------------------------
// Conflict-aware bin packer
// Online bin packing with per-bin conflict masks, first, best or worst fit.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Moves
//  i_in      sink       item: place or clear action, id, weight, conflict mask
//  o_out     source     item: bin index, new-bin flag, remaining room, bins used, overflow
//  i_cfg     sink       register write: capacity (0) or policy (1)
//
//  A place item passes through accept, one registered read per open bin
//  from the bin store, decision and write-back, and hand-over to the output
//  register; first fit stops at the first hit, and a place item with no open
//  bin skips the scan. A clear item goes from accept straight to hand-over.
//  The block takes no new item until the last one is handed over.
//  Reset clears the open-bin count and the control state; the bin store needs
//  no clearing pass, as only opened entries are ever read.
//  The output register holds a result while the next item is accepted and
//  scanned; the block waits in hand-over only if the previous result is unread.
//
module conflict_aware_bin_packer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cabp_in_if.sink    i_in,
    cabp_out_if.source o_out,
    cabp_cfg_if.sink   i_cfg
);
    import cabp_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    // Configuration registers.
    logic [CAP_W-1:0] r_capacity;
    logic [POL_W-1:0] r_policy;

    // Control state.
    logic [1:0]         r_state;
    logic [COUNT_W-1:0] r_open;
    logic [COUNT_W-1:0] r_scan;
    logic               r_chk;
    logic               r_found;
    logic               r_ovalid;

    // Latched item and scan payload.
    logic [BIN_W-1:0]         r_chk_idx;
    logic [MASK_W-1:0]        r_mask;
    logic [MASK_W-1:0]        r_mbit;
    logic [WEIGHT_W-1:0]      r_weight;
    logic [BIN_W-1:0]         r_best_idx;
    logic signed [ROOM_W-1:0] r_best_slack;
    logic [MASK_W-1:0]        r_best_members;

    // Pending result, loaded into the output register at hand-over.
    logic [IDX_OUT_W-1:0]     r_res_idx;
    logic                     r_res_new;
    logic signed [ROOM_W-1:0] r_res_rem;
    logic [USED_W-1:0]        r_res_used;
    logic                     r_res_ovf;

    // Output register.
    logic [IDX_OUT_W-1:0]     r_o_idx;
    logic                     r_o_new;
    logic signed [ROOM_W-1:0] r_o_rem;
    logic [USED_W-1:0]        r_o_used;
    logic                     r_o_ovf;

    // Bin store and its ports.
    t_bin_entry       mem [MAX_BINS];
    t_bin_entry       r_rdata;
    logic             mem_we;
    logic [BIN_W-1:0] mem_waddr;
    t_bin_entry       mem_wdata;

    // Scan evaluation.
    logic signed [ROOM_W-1:0] w_ext;
    logic signed [ROOM_W-1:0] slack;
    logic                     hit;
    logic                     better;
    logic                     first_fit;
    logic                     scan_done;
    logic                     issue;
    logic                     accept;
    logic                     out_free;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;

    // Handshakes and output payload.
    assign i_in.ready          = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_ovalid;
    assign o_out.bin_index     = r_o_idx;
    assign o_out.new_bin       = r_o_new;
    assign o_out.bin_remaining = r_o_rem;
    assign o_out.bins_used     = r_o_used;
    assign o_out.overflow      = r_o_ovf;

    // A bin qualifies when it has room for the weight and holds no conflicting item.
    always_comb begin
        w_ext     = $signed({1'b0, r_weight});
        slack     = r_rdata.room - w_ext;
        hit       = r_chk && (r_rdata.room >= w_ext) && ((r_rdata.members & r_mask) == '0);
        first_fit = (r_policy != POL_BEST) && (r_policy != POL_WORST);
        better    = !r_found ||
                    ((r_policy == POL_BEST) && (slack < r_best_slack)) ||
                    ((r_policy == POL_WORST) && (slack > r_best_slack));
        scan_done = (hit && first_fit) || (r_chk && (r_scan == r_open));
        issue     = (r_state == S_SCAN) && !scan_done && (r_scan < r_open);
    end

    // Write-back of the chosen or newly opened bin.
    always_comb begin
        mem_we            = 1'b0;
        mem_waddr         = r_open[BIN_W-1:0];
        mem_wdata.members = r_mbit;
        mem_wdata.room    = $signed({1'b0, r_capacity}) - w_ext;
        if (r_state == S_DECIDE) begin
            if (r_found) begin
                mem_we            = 1'b1;
                mem_waddr         = r_best_idx;
                mem_wdata.members = r_best_members | r_mbit;
                mem_wdata.room    = r_best_slack;
            end else if (r_open < COUNT_W'(MAX_BINS)) begin
                mem_we = 1'b1;
            end
        end
    end

    // Bin store: one write and one registered read a cycle. Reads and the
    // write-back of one item never overlap, as the sequencer orders them.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_scan[BIN_W-1:0]];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
            r_policy   <= POL_FIRST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == REG_CAPACITY) begin
                r_capacity <= i_cfg.data[CAP_W-1:0];
            end else if (i_cfg.index == REG_POLICY) begin
                r_policy <= i_cfg.data[POL_W-1:0];
            end
        end
    end

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_open   <= '0;
            r_scan   <= '0;
            r_chk    <= 1'b0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_scan  <= '0;
                        r_chk   <= 1'b0;
                        r_found <= 1'b0;
                        if (i_in.action == ACT_CLEAR) begin
                            r_open  <= '0;
                            r_state <= S_EMIT;
                        end else if (r_open == '0) begin
                            r_state <= S_DECIDE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit && better) begin
                        r_found <= 1'b1;
                    end
                    r_chk <= issue;
                    if (issue) begin
                        r_scan <= r_scan + COUNT_W'(1);
                    end
                    if (scan_done) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (!r_found && (r_open < COUNT_W'(MAX_BINS))) begin
                        r_open <= r_open + COUNT_W'(1);
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Item latch, best candidate and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mask   <= i_in.conflict_mask & ITEM_MASK;
            r_mbit   <= (32'(i_in.item_id) < MAX_ITEMS) ?
                        (MASK_W'(1) << i_in.item_id) : '0;
            r_weight <= i_in.weight;
            if (i_in.action == ACT_CLEAR) begin
                r_res_idx  <= '0;
                r_res_new  <= 1'b0;
                r_res_rem  <= '0;
                r_res_used <= '0;
                r_res_ovf  <= 1'b0;
            end
        end
        if (issue) begin
            r_chk_idx <= r_scan[BIN_W-1:0];
        end
        if ((r_state == S_SCAN) && hit && better) begin
            r_best_idx     <= r_chk_idx;
            r_best_slack   <= slack;
            r_best_members <= r_rdata.members;
        end
        if (r_state == S_DECIDE) begin
            if (r_found) begin
                r_res_idx  <= IDX_OUT_W'(r_best_idx);
                r_res_new  <= 1'b0;
                r_res_rem  <= r_best_slack;
                r_res_used <= USED_W'(r_open);
                r_res_ovf  <= 1'b0;
            end else if (r_open < COUNT_W'(MAX_BINS)) begin
                r_res_idx  <= IDX_OUT_W'(r_open[BIN_W-1:0]);
                r_res_new  <= 1'b1;
                r_res_rem  <= mem_wdata.room;
                r_res_used <= USED_W'(r_open + COUNT_W'(1));
                r_res_ovf  <= 1'b0;
            end else begin
                r_res_idx  <= '0;
                r_res_new  <= 1'b0;
                r_res_rem  <= '0;
                r_res_used <= USED_W'(r_open);
                r_res_ovf  <= 1'b1;
            end
        end
        if ((r_state == S_EMIT) && out_free) begin
            r_o_idx  <= r_res_idx;
            r_o_new  <= r_res_new;
            r_o_rem  <= r_res_rem;
            r_o_used <= r_res_used;
            r_o_ovf  <= r_res_ovf;
        end
    end

endmodule
